// ----- hdl/itf_pkg.sv -----
// Shared types and constants for the integer text formatter.
// Used by itf_cell and integer_text_formatter_core; depends on nothing.
`default_nettype none

package itf_pkg;

    // Width of the number to print and of its bit counter.
    localparam int VALUE_W    = 64;
    localparam int BIT_CNT_W  = 6;

    // Digit cells in the chain: enough for the 20 decimal digits of 2^64 - 1.
    localparam int NUM_DIGITS = 20;

    // Field positions and lengths never exceed 21, so five bits hold them.
    localparam int LEN_W      = 5;

    // Conversion codes.
    localparam logic [1:0] OP_SDEC = 2'd0;
    localparam logic [1:0] OP_UDEC = 2'd1;
    localparam logic [1:0] OP_HEXL = 2'd2;
    localparam logic [1:0] OP_HEXU = 2'd3;

    // Bit positions inside pad_flags.
    localparam int FLAG_LEFT  = 0;
    localparam int FLAG_PLUS  = 1;
    localparam int FLAG_SPACE = 2;
    localparam int FLAG_ZERO  = 3;

    // ASCII characters the formatter produces.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_LOWER = 8'h61;

    // What each digit cell does in a cycle.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_SHIFT_BCD,
        CELL_SHIFT_BIN,
        CELL_SHIFT_DIGIT
    } cell_mode_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_ALIGN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/itf_cell.sv -----
// One four-bit digit cell of the conversion chain.
// Depends on itf_pkg for the cell mode type.
`default_nettype none

module itf_cell (
    input  wire logic                clk,
    input  wire itf_pkg::cell_mode_t mode,
    input  wire logic                bit_in,
    input  wire logic [3:0]          digit_in,
    output logic                     bit_out,
    output logic [3:0]               digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] corrected;
    logic [3:0] shift_src;

    // Double dabble correction: a digit of five or more gets three added before the shift.
    assign corrected = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign shift_src = (mode == itf_pkg::CELL_SHIFT_BCD) ? corrected : digit_reg;
    assign bit_out   = shift_src[3];
    assign digit     = digit_reg;

    // Next digit for the selected operation.
    always_comb
    begin
        case (mode)
            itf_pkg::CELL_CLEAR:       digit_next = 4'd0;
            itf_pkg::CELL_SHIFT_BCD:   digit_next = {shift_src[2:0], bit_in};
            itf_pkg::CELL_SHIFT_BIN:   digit_next = {shift_src[2:0], bit_in};
            itf_pkg::CELL_SHIFT_DIGIT: digit_next = digit_in;
            default:                   digit_next = digit_reg;
        endcase
    end

    // Digit storage.
    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

`default_nettype wire

// ----- hdl/integer_text_formatter_core.sv -----
// Integer to printf-style text formatter: sequencer, sign and padding logic.
// Depends on itf_pkg and instantiates a chain of itf_cell digit cells.
`default_nettype none

// One request carries a 64-bit number, a conversion code, padding flags and a
// field width; the block answers with 1 to 21 ASCII characters, the final one
// marked by last. The block accepts a request, shifts the value bit by bit
// through a row of 20 digit cells (with add-three correction for decimal),
// shifts the chain once per leading zero cell to put the top digit at the head,
// sizes the field, and then sends one character per cycle while the output is
// not stalled, each leaving through an output register. A new request is taken
// while the last character still waits.
module integer_text_formatter_core #(
    parameter int DEC_FIELD_MAX = 21,
    parameter int HEX_FIELD_MAX = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [63:0] value,
    input  wire logic [3:0]  pad_flags,
    input  wire logic [7:0]  field_width,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       character,
    output logic             last
);

    localparam int ND = itf_pkg::NUM_DIGITS;
    localparam int LW = itf_pkg::LEN_W;
    localparam int VW = itf_pkg::VALUE_W;
    localparam int CW = itf_pkg::BIT_CNT_W;

    itf_pkg::state_t      state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CW-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [LW-1:0]        nd_reg, nd_next;
    logic [LW-1:0]        pos_reg, pos_next;
    logic [VW-1:0]        value_reg, value_next;
    logic                 hex_reg, hex_next;
    logic                 upper_reg, upper_next;
    logic                 left_reg, left_next;
    logic                 zpad_reg, zpad_next;
    logic                 has_sign_reg, has_sign_next;
    logic [7:0]           sign_char_reg, sign_char_next;
    logic [LW-1:0]        count_reg, count_next;
    logic [LW-1:0]        total_reg, total_next;
    logic [LW-1:0]        pad_reg, pad_next;
    logic [7:0]           character_reg, character_next;
    logic                 last_reg, last_next;

    itf_pkg::cell_mode_t  cell_mode;
    logic [ND:0]          bit_chain;
    logic [3:0]           digits [ND];
    logic [3:0]           top_digit;
    logic [7:0]           digit_char;
    logic                 in_accept;
    logic                 out_free;
    logic                 is_neg;
    logic [LW-1:0]        sign_len;
    logic [LW-1:0]        body_len;
    logic [LW-1:0]        sign_pad;

    // Digit cell chain: bits enter at cell 0, whole digits move toward the top cell.
    assign bit_chain[0] = value_reg[VW-1];

    for (genvar i = 0; i < ND; i++)
    begin : g_cell
        logic [3:0] digit_in;
        if (i == 0)
        begin : g_first
            assign digit_in = 4'd0;
        end
        else
        begin : g_rest
            assign digit_in = digits[i-1];
        end

        itf_cell u_cell (
            .clk      (clk),
            .mode     (cell_mode),
            .bit_in   (bit_chain[i]),
            .digit_in (digit_in),
            .bit_out  (bit_chain[i+1]),
            .digit    (digits[i])
        );
    end

    assign top_digit = digits[ND-1];

    // ASCII for the digit at the head of the chain.
    always_comb
    begin
        if (top_digit <= 4'd9)
        begin
            digit_char = itf_pkg::CH_ZERO + {4'd0, top_digit};
        end
        else
        begin
            digit_char = (upper_reg ? itf_pkg::CH_UPPER : itf_pkg::CH_LOWER)
                         + {4'd0, top_digit} - 8'd10;
        end
    end

    assign in_stall  = (state_reg != itf_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign is_neg    = (opcode == itf_pkg::OP_SDEC) && value[VW-1];
    assign sign_len  = {{(LW-1){1'b0}}, has_sign_reg};
    assign body_len  = nd_reg + sign_len;
    assign sign_pad  = sign_len + pad_reg;

    // Next state, datapath loads and cell control.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        bit_cnt_next   = bit_cnt_reg;
        nd_next        = nd_reg;
        pos_next       = pos_reg;
        value_next     = value_reg;
        hex_next       = hex_reg;
        upper_next     = upper_reg;
        left_next      = left_reg;
        zpad_next      = zpad_reg;
        has_sign_next  = has_sign_reg;
        sign_char_next = sign_char_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        pad_next       = pad_reg;
        character_next = character_reg;
        last_next      = last_reg;
        cell_mode      = itf_pkg::CELL_HOLD;

        // A character taken downstream frees the output register.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            itf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    hex_next   = opcode[1];
                    upper_next = (opcode == itf_pkg::OP_HEXU);
                    left_next  = pad_flags[itf_pkg::FLAG_LEFT];
                    zpad_next  = pad_flags[itf_pkg::FLAG_ZERO];
                    value_next = is_neg ? (~value + 64'd1) : value;
                    if (opcode[1])
                    begin
                        count_next = (field_width > 8'(HEX_FIELD_MAX))
                                     ? LW'(HEX_FIELD_MAX) : field_width[LW-1:0];
                        has_sign_next  = 1'b0;
                        sign_char_next = itf_pkg::CH_SPACE;
                    end
                    else
                    begin
                        count_next = (field_width > 8'(DEC_FIELD_MAX))
                                     ? LW'(DEC_FIELD_MAX) : field_width[LW-1:0];
                        has_sign_next = is_neg || pad_flags[itf_pkg::FLAG_PLUS]
                                        || pad_flags[itf_pkg::FLAG_SPACE];
                        if (is_neg)
                        begin
                            sign_char_next = itf_pkg::CH_MINUS;
                        end
                        else if (pad_flags[itf_pkg::FLAG_PLUS])
                        begin
                            sign_char_next = itf_pkg::CH_PLUS;
                        end
                        else
                        begin
                            sign_char_next = itf_pkg::CH_SPACE;
                        end
                    end
                    bit_cnt_next = '0;
                    nd_next      = LW'(ND);
                    cell_mode    = itf_pkg::CELL_CLEAR;
                    state_next   = itf_pkg::ST_CONVERT;
                end
            end

            itf_pkg::ST_CONVERT:
            begin
                cell_mode    = hex_reg ? itf_pkg::CELL_SHIFT_BIN : itf_pkg::CELL_SHIFT_BCD;
                value_next   = {value_reg[VW-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + CW'(1);
                if (bit_cnt_reg == CW'(VW - 1))
                begin
                    state_next = itf_pkg::ST_ALIGN;
                end
            end

            itf_pkg::ST_ALIGN:
            begin
                // Drop leading zero digits, keeping at least one.
                if ((top_digit == 4'd0) && (nd_reg > LW'(1)))
                begin
                    cell_mode = itf_pkg::CELL_SHIFT_DIGIT;
                    nd_next   = nd_reg - LW'(1);
                end
                else
                begin
                    total_next = (count_reg > body_len) ? count_reg : body_len;
                    pad_next   = ((count_reg > body_len) ? count_reg : body_len) - body_len;
                    pos_next   = '0;
                    state_next = itf_pkg::ST_EMIT;
                end
            end

            itf_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    last_next      = (pos_reg == total_reg - LW'(1));
                    pos_next       = pos_reg + LW'(1);
                    if (left_reg)
                    begin
                        // Sign, digits, then trailing blanks.
                        if (has_sign_reg && (pos_reg == '0))
                        begin
                            character_next = sign_char_reg;
                        end
                        else if (pos_reg < body_len)
                        begin
                            character_next = digit_char;
                            cell_mode      = itf_pkg::CELL_SHIFT_DIGIT;
                        end
                        else
                        begin
                            character_next = itf_pkg::CH_SPACE;
                        end
                    end
                    else if (zpad_reg)
                    begin
                        // Sign, zeros, then digits.
                        if (pos_reg < sign_len)
                        begin
                            character_next = sign_char_reg;
                        end
                        else if (pos_reg < sign_pad)
                        begin
                            character_next = itf_pkg::CH_ZERO;
                        end
                        else
                        begin
                            character_next = digit_char;
                            cell_mode      = itf_pkg::CELL_SHIFT_DIGIT;
                        end
                    end
                    else
                    begin
                        // Leading blanks, sign, then digits.
                        if (pos_reg < pad_reg)
                        begin
                            character_next = itf_pkg::CH_SPACE;
                        end
                        else if (has_sign_reg && (pos_reg == pad_reg))
                        begin
                            character_next = sign_char_reg;
                        end
                        else
                        begin
                            character_next = digit_char;
                            cell_mode      = itf_pkg::CELL_SHIFT_DIGIT;
                        end
                    end
                    if (pos_reg == total_reg - LW'(1))
                    begin
                        state_next = itf_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = itf_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            nd_reg        <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            nd_reg        <= nd_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        hex_reg       <= hex_next;
        upper_reg     <= upper_next;
        left_reg      <= left_next;
        zpad_reg      <= zpad_next;
        has_sign_reg  <= has_sign_next;
        sign_char_reg <= sign_char_next;
        count_reg     <= count_next;
        total_reg     <= total_next;
        pad_reg       <= pad_next;
        character_reg <= character_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign character = character_reg;
    assign last      = last_reg;

    // A request always starts a fresh conversion.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == itf_pkg::ST_CONVERT) && (bit_cnt_reg == '0))
        else $error("conversion did not start after a request");

    // Twenty decimal cells never overflow out of the top cell.
    a_no_bcd_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_mode == itf_pkg::CELL_SHIFT_BCD) |-> !bit_chain[ND])
        else $error("decimal digit chain overflowed");

    // Alignment keeps at least one digit.
    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itf_pkg::ST_ALIGN || state_reg == itf_pkg::ST_EMIT)
        |-> (nd_reg >= LW'(1)) && (nd_reg <= LW'(ND)))
        else $error("digit count out of range");

    // The emit position never runs past the field.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itf_pkg::ST_EMIT) |-> (pos_reg < total_reg))
        else $error("character position past end of field");

endmodule

`default_nettype wire
